[rtl/pds_pkg.sv]
// Shared constants, status codes and small helper functions for the
// polar decomposition strain block. No dependencies.
`default_nettype none

package pds_pkg;

    localparam int MAX_ITERATIONS_DEF = 32;
    localparam int FRACTION_BITS_DEF  = 24;

    localparam logic [30:0] LIMIT_RESET = 31'd17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SING_GRAD = 2'd1;
    localparam logic [1:0] ST_SING_ITER = 2'd2;
    localparam logic [1:0] ST_NO_CONV   = 2'd3;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sh0_7FFF_FFFF)
            res = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            res = -32'sh8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

    // Next row or column index modulo three.
    function automatic logic [1:0] inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // Flat element index of row r, column c.
    function automatic logic [3:0] elem(input logic [1:0] r, input logic [1:0] c);
        return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

[rtl/polar_decomposition_strain_3x3.sv]
// Polar decomposition strain unit: one word in, one word out, one at a time.
// An inversion runs the bit-serial divider nine times, on Q8.24 values by default; a
// word with n iterations takes n+2 inversions, n+1 averaging passes and a pass for U,
// det(U) and the Q8.24 output word, plus output stalls; a singular gradient ends after
// its first determinant. A new word is taken only once the last one has left the
// sequencer; s_tready is high only between words. Reset
// (rst_n, asynchronous, active low) idles the sequencer and sets the limit to 17.
`default_nettype none

module polar_decomposition_strain_3x3
#(
    parameter int MAX_ITERATIONS = pds_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = pds_pkg::FRACTION_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // g00, g01, g02, g10, g11, g12, g20, g21, g22 (32 bits each)
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // trace_strain[31:0], volume_strain[63:32], status[65:64],
    // iteration_count[72:66], zero fill
    output logic [79:0]       m_tdata,
    input  wire logic         cfg_wen,
    input  wire logic [30:0]  cfg_wdata
);
    import pds_pkg::*;

    localparam logic signed [63:0] Q_ONE   = 64'sd1 <<< FRACTION_BITS;
    localparam logic signed [35:0] Q_THREE = 36'sd3 <<< FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_COF_A, S_COF_B, S_COF_C, S_DET_A, S_DET_B, S_DET_END,
        S_DIV_ST, S_DIV_W, S_AVG, S_U_A, S_U_B, S_TRACE, S_DONE
    } state_t;

    // Which matrix the cofactor pass works on, and what follows.
    typedef enum logic [1:0] { PH_INIT, PH_ITER, PH_FINAL, PH_UDET } phase_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [1:0]  row_reg;
    logic [1:0]  col_reg;
    logic [1:0]  k_reg;
    logic [3:0]  idx_reg;
    logic [6:0]  count_reg;
    logic        m_tvalid_reg;
    logic [30:0] limit_reg;

    logic signed [31:0] f_reg   [9];
    logic signed [31:0] r_reg   [9];
    logic signed [31:0] t_reg   [9];
    logic signed [31:0] u_reg   [9];
    logic signed [31:0] cof_reg [9];
    logic signed [63:0] acc_reg;
    logic signed [63:0] det_reg;
    logic [32:0]        maxch_reg;
    logic signed [31:0] res_trace_reg;
    logic signed [31:0] res_vol_reg;
    logic [1:0]         res_status_reg;
    logic [79:0]        m_tdata_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_prod;
    logic signed [63:0] prod_floor;
    logic signed [64:0] minor;
    logic signed [64:0] minor_fl;
    logic signed [63:0] acc_next;
    logic               div_done;
    logic signed [31:0] div_q;
    logic [1:0]         r1;
    logic [1:0]         r2;
    logic [1:0]         c1;
    logic [1:0]         c2;
    logic               last_rc;
    logic               accept;
    logic               out_free;
    logic signed [31:0] avg_a;
    logic signed [32:0] avg_sum;
    logic signed [31:0] avg_nv;
    logic signed [32:0] avg_ch;
    logic [32:0]        ch_abs;
    logic [32:0]        maxch_new;
    logic               converged;
    logic signed [35:0] trace_sum;

    function automatic logic signed [31:0] msel(input logic [3:0] i);
        logic signed [31:0] v;
        unique case (phase_reg)
            PH_INIT:  v = f_reg[i];
            PH_ITER:  v = r_reg[i];
            PH_FINAL: v = r_reg[i];
            PH_UDET:  v = u_reg[i];
            default:  v = f_reg[i];
        endcase
        return v;
    endfunction

    assign r1 = inc3(row_reg);
    assign r2 = inc3(r1);
    assign c1 = inc3(col_reg);
    assign c2 = inc3(c1);
    assign last_rc = (row_reg == 2'd2) && (col_reg == 2'd2);

    always_comb
    begin
        unique case (state_reg)
            S_COF_A:
            begin
                mul_a = msel(elem(r1, c1));
                mul_b = msel(elem(r2, c2));
            end
            S_COF_B:
            begin
                mul_a = msel(elem(r1, c2));
                mul_b = msel(elem(r2, c1));
            end
            S_DET_A:
            begin
                mul_a = msel({2'b00, k_reg});
                mul_b = cof_reg[{2'b00, k_reg}];
            end
            S_U_A:
            begin
                mul_a = t_reg[elem(k_reg, row_reg)];
                mul_b = f_reg[elem(k_reg, col_reg)];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pds_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    pds_div #(.FRACTION_BITS(FRACTION_BITS)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_ST),
        .cof      (cof_reg[idx_reg]),
        .det      (det_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prod_floor = mul_prod >>> FRACTION_BITS;
    assign minor      = 65'(acc_reg) - 65'(mul_prod);
    assign minor_fl   = minor >>> FRACTION_BITS;
    assign acc_next   = acc_reg + prod_floor;

    // Averaging step: new = floor((a + t) / 2), change tracked as its magnitude.
    assign avg_a     = (phase_reg == PH_INIT) ? f_reg[idx_reg] : r_reg[idx_reg];
    assign avg_sum   = 33'(avg_a) + 33'(t_reg[idx_reg]);
    assign avg_nv    = avg_sum[32:1];
    assign avg_ch    = 33'(avg_nv) - 33'(avg_a);
    assign ch_abs    = avg_ch[32] ? 33'(-avg_ch) : 33'(avg_ch);
    assign maxch_new = (ch_abs > maxch_reg) ? ch_abs : maxch_reg;
    assign converged = maxch_new <= {2'b00, limit_reg};

    assign trace_sum = 36'(u_reg[0]) + 36'(u_reg[4]) + 36'(u_reg[8]) - Q_THREE;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_wen)
                limit_reg <= cfg_wdata;
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        phase_reg <= PH_INIT;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= S_COF_A;
                    end
                end
                S_COF_A: state_reg <= S_COF_B;
                S_COF_B: state_reg <= S_COF_C;
                S_COF_C:
                begin
                    if (last_rc)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DET_A;
                    end
                    else
                    begin
                        if (col_reg == 2'd2)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                        end
                        else
                            col_reg <= col_reg + 2'd1;
                        state_reg <= S_COF_A;
                    end
                end
                S_DET_A: state_reg <= S_DET_B;
                S_DET_B:
                begin
                    if (k_reg == 2'd2)
                        state_reg <= S_DET_END;
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_DET_A;
                    end
                end
                S_DET_END:
                begin
                    if (phase_reg == PH_UDET || det_reg == '0)
                        state_reg <= S_DONE;
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_DIV_ST;
                    end
                end
                S_DIV_ST: state_reg <= S_DIV_W;
                S_DIV_W:
                begin
                    if (div_done)
                    begin
                        if (idx_reg == 4'd8)
                        begin
                            idx_reg <= '0;
                            row_reg <= '0;
                            col_reg <= '0;
                            k_reg   <= '0;
                            state_reg <= (phase_reg == PH_FINAL) ? S_U_A : S_AVG;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= S_DIV_ST;
                        end
                    end
                end
                S_AVG:
                begin
                    if (idx_reg == 4'd8)
                    begin
                        row_reg <= '0;
                        col_reg <= '0;
                        if (phase_reg == PH_INIT)
                        begin
                            phase_reg <= PH_ITER;
                            state_reg <= S_COF_A;
                        end
                        else
                        begin
                            count_reg <= count_reg + 7'd1;
                            if (converged)
                            begin
                                phase_reg <= PH_FINAL;
                                state_reg <= S_COF_A;
                            end
                            else if (count_reg + 7'd1 == 7'(MAX_ITERATIONS))
                                state_reg <= S_DONE;
                            else
                                state_reg <= S_COF_A;
                        end
                    end
                    else
                        idx_reg <= idx_reg + 4'd1;
                end
                S_U_A: state_reg <= S_U_B;
                S_U_B:
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (last_rc)
                            state_reg <= S_TRACE;
                        else
                        begin
                            if (col_reg == 2'd2)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + 2'd1;
                            end
                            else
                                col_reg <= col_reg + 2'd1;
                            state_reg <= S_U_A;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_U_A;
                    end
                end
                S_TRACE:
                begin
                    phase_reg <= PH_UDET;
                    row_reg   <= '0;
                    col_reg   <= '0;
                    state_reg <= S_COF_A;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    for (int i = 0; i < 9; i++)
                        f_reg[i] <= s_tdata[32*i +: 32];
                end
            end
            S_COF_B: acc_reg <= mul_prod;
            S_COF_C:
            begin
                cof_reg[elem(row_reg, col_reg)] <= sat32(66'(minor_fl));
                if (last_rc)
                    det_reg <= '0;
            end
            S_DET_B: det_reg <= det_reg + prod_floor;
            S_DET_END:
            begin
                if (phase_reg == PH_UDET)
                begin
                    res_vol_reg    <= sat32(66'(det_reg - Q_ONE));
                    res_status_reg <= ST_OK;
                end
                else if (det_reg == '0)
                begin
                    res_trace_reg  <= '0;
                    res_vol_reg    <= '0;
                    res_status_reg <= (phase_reg == PH_INIT) ? ST_SING_GRAD : ST_SING_ITER;
                end
            end
            S_DIV_W:
            begin
                if (div_done)
                begin
                    t_reg[idx_reg] <= div_q;
                    maxch_reg      <= '0;
                    acc_reg        <= '0;
                end
            end
            S_AVG:
            begin
                r_reg[idx_reg] <= avg_nv;
                maxch_reg      <= maxch_new;
                res_trace_reg  <= '0;
                res_vol_reg    <= '0;
                res_status_reg <= ST_NO_CONV;
            end
            S_U_B:
            begin
                if (k_reg == 2'd2)
                begin
                    u_reg[elem(row_reg, col_reg)] <= sat32(66'(acc_next));
                    acc_reg <= '0;
                end
                else
                    acc_reg <= acc_next;
            end
            S_TRACE: res_trace_reg <= sat32(66'(trace_sum));
            S_DONE:
            begin
                if (out_free)
                    m_tdata_reg <= {7'd0, count_reg, res_status_reg,
                                    res_vol_reg, res_trace_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // A failed word carries zero strain.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65:64] != ST_OK) |-> (m_tdata[63:0] == 64'd0))
        else $error("failed word carries nonzero strain");

    // No convergence is reported only after the full iteration budget.
    a_noconv_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65:64] == ST_NO_CONV) |-> (m_tdata[72:66] == 7'(MAX_ITERATIONS)))
        else $error("no convergence with short iteration count");

    // A singular gradient is found before any averaging step.
    a_grad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65:64] == ST_SING_GRAD) |-> (m_tdata[72:66] == 7'd0))
        else $error("singular gradient with nonzero count");

    // The sequencer never runs past the iteration budget.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg <= 7'(MAX_ITERATIONS)))
        else $error("iteration count beyond budget");
`endif

endmodule

`default_nettype wire

[rtl/pds_mul.sv]
// Shared signed 32x32 multiplier with a registered 64-bit product.
// No dependencies beyond pds_pkg.
`default_nettype none

module pds_mul
(
    input  wire logic               clk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [63:0]      prod
);
    import pds_pkg::*;

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/pds_div.sv]
// Restoring divider, one quotient bit per cycle: (cof * 2^FRACTION_BITS) / det,
// truncated toward zero and saturated to 32 bits. Uses pds_pkg.
`default_nettype none

module pds_div
#(
    parameter int FRACTION_BITS = pds_pkg::FRACTION_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] cof,
    input  wire logic signed [63:0] det,
    output logic                    done,
    output logic signed [31:0]      quotient
);
    import pds_pkg::*;

    localparam int DIV_BITS = 32 + FRACTION_BITS;
    localparam int CW = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] num_reg;
    logic [63:0]         rem_reg;
    logic [63:0]         den_reg;
    logic                neg_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                fin_reg;

    logic [31:0] cof_abs;
    logic [64:0] rem_sh;
    logic [64:0] rem_diff;
    logic        qbit;
    logic        over_pos;
    logic        over_neg;

    assign cof_abs  = cof[31] ? 32'(-cof) : 32'(cof);
    assign rem_sh   = {rem_reg, num_reg[DIV_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign qbit     = !rem_diff[64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {cof_abs, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= det[63] ? 64'(-det) : 64'(det);
            neg_reg <= cof[31] ^ det[63];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? rem_diff[63:0] : rem_sh[63:0];
            num_reg <= {num_reg[DIV_BITS-2:0], qbit};
        end
    end

    assign over_pos = |num_reg[DIV_BITS-1:31];
    assign over_neg = (|num_reg[DIV_BITS-1:32]) || (num_reg[31] && (|num_reg[30:0]));

    always_comb
    begin
        if (neg_reg)
            quotient = over_neg ? -32'sh8000_0000 : -$signed(num_reg[31:0]);
        else
            quotient = over_pos ? 32'sh7FFF_FFFF : $signed(num_reg[31:0]);
    end

    assign done = fin_reg;

endmodule

`default_nettype wire

[bench/polar_decomposition_strain_3x3_tb.sv]
// Self-checking bench for polar_decomposition_strain_3x3: stream words in, predicts
// trace/volume strain, status and step count in a local model, checks every result.
// Needs rtl/pds_pkg.sv, polar_decomposition_strain_3x3.sv, pds_mul.sv, pds_div.sv.
`default_nettype none

module polar_decomposition_strain_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    localparam int     FB    = FRACTION_BITS_DEF;
    localparam int     MAXIT = MAX_ITERATIONS_DEF;
    localparam longint QONE  = longint'(1) << FB;

    typedef longint mat_t [9];

    typedef struct packed {
        logic [6:0]         steps;
        logic [1:0]         status;
        logic signed [31:0] volume;
        logic signed [31:0] trace;
    } strain_t;

    class strain_scoreboard;
        strain_t   pending[$];
        longint    limit;
        int        mismatches;

        function new();
            limit      = longint'(LIMIT_RESET);
            mismatches = 0;
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Saturated cofactors of m; returns the unsaturated determinant.
        static function longint cofactor_det(input mat_t m, output mat_t cf);
            int     r1, r2, c1, c2;
            longint minor;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    r1 = (r + 1) % 3;
                    r2 = (r + 2) % 3;
                    c1 = (c + 1) % 3;
                    c2 = (c + 2) % 3;
                    minor = m[r1*3+c1] * m[r2*3+c2] - m[r1*3+c2] * m[r2*3+c1];
                    cf[r*3+c] = clamp32(minor >>> FB);
                end
            end
            return ((m[0] * cf[0]) >>> FB) + ((m[1] * cf[1]) >>> FB)
                 + ((m[2] * cf[2]) >>> FB);
        endfunction

        static function bit inverse_t(input mat_t m, output mat_t it);
            mat_t   cf;
            longint det;
            det = cofactor_det(m, cf);
            if (det == 0)
                return 0;
            for (int i = 0; i < 9; i++)
                it[i] = clamp32((cf[i] * QONE) / det);
            return 1;
        endfunction

        function strain_t predict(input logic [287:0] word);
            mat_t    f, r, t, u, cf;
            longint  s, nv, ch, maxch, d;
            int      steps;
            bit      done;
            strain_t e;
            e = '0;
            steps = 0;
            done = 0;
            for (int i = 0; i < 9; i++)
                f[i] = longint'($signed(word[32*i +: 32]));
            if (!inverse_t(f, t))
            begin
                e.status = ST_SING_GRAD;
                return e;
            end
            for (int i = 0; i < 9; i++)
                r[i] = (f[i] + t[i]) >>> 1;
            while (steps < MAXIT && !done)
            begin
                maxch = 0;
                if (!inverse_t(r, t))
                begin
                    e.status = ST_SING_ITER;
                    e.steps  = 7'(steps);
                    return e;
                end
                for (int i = 0; i < 9; i++)
                begin
                    s  = r[i] + t[i];
                    nv = s >>> 1;
                    ch = nv - r[i];
                    if (ch < 0)
                        ch = -ch;
                    if (ch > maxch)
                        maxch = ch;
                    r[i] = nv;
                end
                steps++;
                if (maxch <= limit)
                    done = 1;
            end
            e.steps = 7'(steps);
            if (!done)
            begin
                e.status = ST_NO_CONV;
                return e;
            end
            if (!inverse_t(r, t))
            begin
                e.status = ST_SING_ITER;
                return e;
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s = 0;
                    for (int k = 0; k < 3; k++)
                        s += (t[k*3+i] * f[k*3+j]) >>> FB;
                    u[i*3+j] = clamp32(s);
                end
            end
            d = cofactor_det(u, cf);
            e.status = ST_OK;
            e.trace  = 32'(clamp32(u[0] + u[4] + u[8] - 3 * QONE));
            e.volume = 32'(clamp32(d - QONE));
            return e;
        endfunction

        function void note_gradient(input logic [287:0] word);
            pending.push_back(predict(word));
        endfunction

        function void check_strain(input logic [79:0] data);
            strain_t got, want;
            got = data[72:0];
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", data);
                return;
            end
            want = pending.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: trace exp %0d got %0d, volume exp %0d got %0d, ",
                              "status exp %0d got %0d, steps exp %0d got %0d"},
                             want.trace, got.trace, want.volume, got.volume,
                             want.status, got.status, want.steps, got.steps);
            end
            if (data[79:73] != 7'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("nonzero fill bits in result word %h", data);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         cfg_wen;
    logic [30:0]  cfg_wdata;

    strain_scoreboard sb;
    bit               ready_free;
    int               stall_left;

    polar_decomposition_strain_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver stalls: mostly short, now and then long, with stall-free stretches.
    always @(negedge clk)
    begin
        if (ready_free)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            stall_left <= $urandom_range(20, 300);
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 40)
            m_tready <= ~m_tready;
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 999) == 0)
            ready_free <= ~ready_free;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_strain(m_tdata);
    end

    initial
    begin
        #(64'd2_000_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_gradient(input logic [31:0] g [9]);
        int gap;
        for (int i = 0; i < 9; i++)
            s_tdata[32*i +: 32] = g[i];
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_gradient(s_tdata);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            s_tdata  = {9{$urandom()}};
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_limit(input logic [30:0] v);
        wait_drained();
        cfg_wen   = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_wen   = 1'b0;
        sb.limit  = longint'(v);
    endtask

    // Signed permutation times a stretch, plus bounded noise.
    task automatic make_deformation(output logic [31:0] g [9]);
        int     col [3];
        longint stretch, amp, v;
        col[0] = $urandom_range(0, 2);
        col[1] = (col[0] + 1 + $urandom_range(0, 1)) % 3;
        col[2] = 3 - col[0] - col[1];
        amp = QONE >> $urandom_range(1, 12);
        for (int i = 0; i < 9; i++)
        begin
            v = $signed($urandom_range(0, 32'(2 * amp))) - amp;
            if (i % 3 == col[i / 3])
            begin
                stretch = QONE / 4 + $urandom_range(0, 32'(4 * QONE));
                v += ($urandom_range(0, 1) ? stretch : -stretch);
            end
            g[i] = v[31:0];
        end
    endtask

    task automatic make_noise(output logic [31:0] g [9]);
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < 9; i++)
            g[i] = (mode == 0) ? $urandom()
                 : 32'($signed($urandom_range(0, 32'(8 * QONE))) - 4 * QONE);
        // Repeated row gives a singular gradient.
        if (mode == 2)
        begin
            g[6] = g[0];
            g[7] = g[1];
            g[8] = g[2];
        end
    endtask

    task automatic run_random(input int count);
        logic [31:0] g [9];
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                make_noise(g);
            else
                make_deformation(g);
            send_gradient(g);
        end
    endtask

    task automatic send_fill(input logic [31:0] diag, input logic [31:0] off);
        logic [31:0] g [9];
        for (int i = 0; i < 9; i++)
            g[i] = (i % 4 == 0) ? diag : off;
        send_gradient(g);
    endtask

    initial
    begin
        logic [31:0] g [9];
        sb         = new();
        ready_free = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_wen    = 1'b0;
        cfg_wdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words with the reset limit.
        send_fill(32'h0100_0000, 32'h0);            // identity
        send_fill(32'h0, 32'h0);                    // zero gradient
        send_fill(32'h7FFF_FFFF, 32'h7FFF_FFFF);    // all maximum, rank one
        send_fill(32'h8000_0000, 32'h8000_0000);    // all minimum
        send_fill(32'h7FFF_FFFF, 32'h0);            // saturating stretch
        send_fill(32'h8000_0000, 32'h0);            // large reflection
        send_fill(32'h0000_0001, 32'h0);            // determinant floors to zero
        send_fill(32'hFF00_0000, 32'h0);            // minus identity
        send_fill(32'h0200_0000, 32'h0080_0000);    // symmetric stretch
        send_fill(32'h0000_1000, 32'h0000_0100);    // tiny, near singular
        send_fill(32'hAAAA_AAAA, 32'h5555_5555);
        send_fill(32'h5555_5555, 32'hAAAA_AAAA);
        g = '{32'h0, 32'h0100_0000, 32'h0, 32'hFF00_0000, 32'h0, 32'h0,
              32'h0, 32'h0, 32'h0100_0000};
        send_gradient(g);                           // pure rotation
        g = '{32'h0, 32'h0100_0000, 32'h0, 32'h0100_0000, 32'h0, 32'h0,
              32'h0, 32'h0, 32'h0100_0000};
        send_gradient(g);                           // reflection, det -1
        g = '{32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 32'h0400_0000,
              32'h0500_0000, 32'h0600_0000, 32'h0700_0000, 32'h0800_0000,
              32'h0900_0000};
        send_gradient(g);                           // singular 1..9
        g = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0100_0000,
              32'h0, 32'h0, 32'h0, 32'h0100_0000};
        send_gradient(g);                           // extreme shear
        for (int n = 0; n < 4; n++)
        begin
            for (int i = 0; i < 9; i++)
                g[i] = $urandom();
            send_gradient(g);
        end

        run_random(450);
        // Hold off until every result is back, then continue.
        wait_drained();
        run_random(450);

        write_limit(31'h7FFF_FFFF);
        run_random(250);
        write_limit(31'd0);
        run_random(20);
        write_limit(31'd1);
        run_random(60);
        write_limit(31'($urandom_range(0, 65535)));
        run_random(200);
        write_limit(31'($urandom()));
        run_random(40);

        wait_drained();
        repeat (200) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
